>>> rtl/multi_queue_message_mailbox_defines.svh
// -----------------------------------------------------------------------------
// multi_queue_message_mailbox defines
// Assertion macros used by the mailbox checker.
// -----------------------------------------------------------------------------
`ifndef MULTI_QUEUE_MESSAGE_MAILBOX_DEFINES_SVH
`define MULTI_QUEUE_MESSAGE_MAILBOX_DEFINES_SVH

// same-cycle implication
`define MQMM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mailbox check failed");

// next-cycle implication
`define MQMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mailbox check failed");

`endif

>>> rtl/mqmm_pkg.sv
// -----------------------------------------------------------------------------
// mqmm_pkg
// Types, codes and sizes of the multi-queue message mailbox.
// -----------------------------------------------------------------------------
package mqmm_pkg;

	localparam int NUM_QUEUES   = 16;
	localparam int RING_DEPTH   = 64;
	localparam int PAYLOAD_BITS = 32;
	localparam int TYPE_BITS    = 32;

	localparam int QW       = $clog2(NUM_QUEUES);
	localparam int PW       = $clog2(RING_DEPTH);
	localparam int CW       = $clog2(RING_DEPTH + 1);
	localparam int AW       = QW + PW;
	localparam int ENTRY_W  = TYPE_BITS + PAYLOAD_BITS;

	localparam int IN_RAW   = 3 + 4 + TYPE_BITS + PAYLOAD_BITS + 8 + 7;
	localparam int IN_BITS  = ((IN_RAW + 7) / 8) * 8;
	localparam int OUT_RAW  = 3 + 4 + TYPE_BITS + PAYLOAD_BITS + 7 + 7 + 7;
	localparam int OUT_BITS = ((OUT_RAW + 7) / 8) * 8;

	typedef enum logic [2:0] {
		FN_ALLOC  = 3'd0,
		FN_SEND   = 3'd1,
		FN_RECV   = 3'd2,
		FN_STAT   = 3'd3,
		FN_SETLIM = 3'd4,
		FN_REMOVE = 3'd5
	} func_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NOTUSE   = 3'd1,
		ST_BADSIZE  = 3'd2,
		ST_FULL     = 3'd3,
		ST_EMPTY    = 3'd4,
		ST_MISMATCH = 3'd5,
		ST_NOFREE   = 3'd6
	} status_t;

	// func, the first field of the command, in the lowest bits
	typedef struct packed {
		logic [IN_BITS-IN_RAW-1:0]   pad;
		logic [6:0]                  new_limit;
		logic [7:0]                  msg_size;
		logic [PAYLOAD_BITS-1:0]     msg_payload;
		logic signed [TYPE_BITS-1:0] msg_type;
		logic [3:0]                  queue_id;
		func_t                       func;
	} cmd_t;

	typedef struct packed {
		logic [OUT_BITS-OUT_RAW-1:0] pad;
		logic [6:0]                  queue_limit;
		logic [6:0]                  queue_count;
		logic [6:0]                  out_size;
		logic [PAYLOAD_BITS-1:0]     out_payload;
		logic signed [TYPE_BITS-1:0] out_type;
		logic [3:0]                  granted_queue;
		status_t                     status;
	} result_t;

	typedef struct packed {
		logic [CW-1:0] limit;
		logic [PW-1:0] tail;
		logic [PW-1:0] head;
		logic [CW-1:0] count;
	} desc_t;

	localparam desc_t DESC_RESET = '{limit: CW'(RING_DEPTH), tail: '0, head: '0, count: '0};

endpackage

>>> rtl/multi_queue_message_mailbox.sv
// -----------------------------------------------------------------------------
// multi_queue_message_mailbox
// Message mailbox: NUM_QUEUES rings sharing one message memory.
// -----------------------------------------------------------------------------
// Commands arrive on the s_axis channel, one per transfer; each gives exactly
// one result transfer on m_axis (status, granted queue, received message,
// count and limit).
// Queue descriptors (count, head, tail, limit) sit in a synchronous memory,
// messages in a second one; both are read into registers.
// A command is taken only while the block is idle. The descriptor is read
// as the command is taken; in S_EXEC the block decides, writes back and loads
// the result register. A receive goes on to S_MSG for a further message
// memory read before it finishes. The result register holds its transfer
// until m_axis_tready; a new result waits for it, and no command is taken
// meanwhile. Reset frees all queues; descriptors not yet written read as
// empty with the limit at ring depth, through a per-queue valid bit. No
// clearing pass.
// -----------------------------------------------------------------------------
module multi_queue_message_mailbox (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// func, queue_id, msg_type, msg_payload, msg_size, new_limit
	input  logic [mqmm_pkg::IN_BITS-1:0]  s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// status, granted_queue, out_type, out_payload, out_size, queue_count, queue_limit
	output logic [mqmm_pkg::OUT_BITS-1:0] m_axis_tdata
);
	import mqmm_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_MSG} state_t;

	state_t                  state_q;
	cmd_t                    cmd_q;
	logic [NUM_QUEUES-1:0]   active_q;
	logic [NUM_QUEUES-1:0]   desc_vld_q;
	logic                    desc_vld_s1;
	desc_t                   desc_rd_s1;
	logic [ENTRY_W-1:0]      store_rd_s1;
	logic                    out_vld_q;
	result_t                 out_q;

	desc_t                   desc_mem [NUM_QUEUES];
	logic [ENTRY_W-1:0]      store_mem [NUM_QUEUES*RING_DEPTH];

	cmd_t                    in_cmd;
	logic                    accept;
	logic [QW-1:0]           qi;
	desc_t                   desc_cur;
	logic                    live;
	logic                    size_bad;
	logic                    slot_free;
	logic                    free_found;
	logic [QW-1:0]           free_idx;
	logic                    positive;
	logic [TYPE_BITS-1:0]    head_type;

	result_t                 res;
	logic                    finish;
	logic                    go_msg;
	logic                    desc_we;
	desc_t                   desc_wd;
	logic                    store_we;
	logic                    act_set;
	logic                    act_clr;
	logic                    commit;

	assign in_cmd        = cmd_t'(s_axis_tdata);
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid & s_axis_tready;
	assign qi            = cmd_q.queue_id[QW-1:0];
	assign desc_cur      = desc_vld_s1 ? desc_rd_s1 : DESC_RESET;
	assign live          = active_q[qi];
	assign size_bad      = 32'(cmd_q.msg_size) > 32'(RING_DEPTH);
	assign slot_free     = !out_vld_q || m_axis_tready;
	assign positive      = (cmd_q.msg_type != '0) && !cmd_q.msg_type[TYPE_BITS-1];
	assign head_type     = store_rd_s1[TYPE_BITS-1:0];
	assign commit        = finish && slot_free;

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;

	// lowest free queue
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_found = 1'b1;
				free_idx   = QW'(i);
			end
		end
	end

	always_comb begin
		res      = '0;
		res.status = ST_OK;
		finish   = 1'b0;
		go_msg   = 1'b0;
		desc_we  = 1'b0;
		desc_wd  = desc_cur;
		store_we = 1'b0;
		act_set  = 1'b0;
		act_clr  = 1'b0;
		unique case (state_q)
			S_EXEC: begin
				finish = 1'b1;
				if (cmd_q.func == FN_ALLOC) begin
					if (free_found) begin
						act_set           = 1'b1;
						res.granted_queue = 4'(free_idx);
					end else begin
						res.status = ST_NOFREE;
					end
				end else if (!live) begin
					res.status = ST_NOTUSE;
				end else begin
					case (cmd_q.func)
						FN_SEND: begin
							if (size_bad) begin
								res.status = ST_BADSIZE;
							end else if (desc_cur.count >= desc_cur.limit) begin
								res.status = ST_FULL;
							end else begin
								store_we      = 1'b1;
								desc_we       = 1'b1;
								desc_wd.tail  = desc_cur.tail + PW'(1);
								desc_wd.count = desc_cur.count + CW'(1);
							end
						end
						FN_RECV: begin
							if (size_bad) begin
								res.status = ST_BADSIZE;
							end else if (desc_cur.count == '0) begin
								res.status = ST_EMPTY;
							end else begin
								finish = 1'b0;
								go_msg = 1'b1;
							end
						end
						FN_STAT: begin
							res.queue_count = 7'(desc_cur.count);
							res.queue_limit = 7'(desc_cur.limit);
						end
						FN_SETLIM: begin
							desc_we       = 1'b1;
							desc_wd.limit = (32'(cmd_q.new_limit) > 32'(RING_DEPTH)) ?
								CW'(RING_DEPTH) : CW'(cmd_q.new_limit);
						end
						FN_REMOVE: begin
							act_clr       = 1'b1;
							desc_we       = 1'b1;
							desc_wd.count = '0;
							desc_wd.head  = '0;
							desc_wd.tail  = '0;
						end
						default: begin
							res.status = ST_NOTUSE;
						end
					endcase
				end
			end
			S_MSG: begin
				finish = 1'b1;
				if (positive && (head_type != cmd_q.msg_type)) begin
					res.status = ST_MISMATCH;
				end else begin
					res.out_type    = head_type;
					res.out_payload = store_rd_s1[ENTRY_W-1:TYPE_BITS];
					res.out_size    = cmd_q.msg_size[6:0];
					desc_we         = 1'b1;
					desc_wd.head    = desc_cur.head + PW'(1);
					desc_wd.count   = desc_cur.count - CW'(1);
				end
			end
			S_IDLE: begin
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			active_q    <= '0;
			desc_vld_q  <= '0;
			desc_vld_s1 <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (commit) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			if (accept) begin
				desc_vld_s1 <= desc_vld_q[in_cmd.queue_id[QW-1:0]];
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC, S_MSG: begin
					if (go_msg) begin
						state_q <= S_MSG;
					end else if (commit) begin
						state_q   <= S_IDLE;
						if (act_set) begin
							active_q[free_idx] <= 1'b1;
						end
						if (act_clr) begin
							active_q[qi] <= 1'b0;
						end
						if (desc_we) begin
							desc_vld_q[qi] <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// command and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= in_cmd;
		end
		if (commit) begin
			out_q <= res;
		end
	end

	// descriptor memory
	always_ff @(posedge clk) begin
		if (commit && desc_we) begin
			desc_mem[qi] <= desc_wd;
		end
		if (accept) begin
			desc_rd_s1 <= desc_mem[in_cmd.queue_id[QW-1:0]];
		end
	end

	// message memory
	always_ff @(posedge clk) begin
		if (commit && store_we) begin
			store_mem[{qi, desc_cur.tail}] <= {cmd_q.msg_payload, cmd_q.msg_type};
		end
		if (go_msg) begin
			store_rd_s1 <= store_mem[{qi, desc_cur.head}];
		end
	end

endmodule

>>> rtl/mqmm_checker.sv
// -----------------------------------------------------------------------------
// mqmm_checker
// Port-level checks of the multi-queue message mailbox.
// -----------------------------------------------------------------------------
`include "multi_queue_message_mailbox_defines.svh"

module mqmm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic [mqmm_pkg::IN_BITS-1:0]  s_axis_tdata,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [mqmm_pkg::OUT_BITS-1:0] m_axis_tdata
);
	import mqmm_pkg::*;

	result_t rsp;
	cmd_t    cmd;

	assign rsp = result_t'(m_axis_tdata);
	assign cmd = cmd_t'(s_axis_tdata);

	// one command in flight
	`MQMM_ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// no status code beyond none free
	`MQMM_ASSERT_NOW(a_status_code, clk, arst_n, m_axis_tvalid, rsp.status <= ST_NOFREE)

	// failed commands return no message
	`MQMM_ASSERT_NOW(a_fail_clean, clk, arst_n, m_axis_tvalid && (rsp.status != ST_OK), (rsp.out_type == '0) && (rsp.out_payload == '0) && (rsp.out_size == '0))

	// stalled result holds
	`MQMM_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// a rising result valid never directly follows a taken command, checked only while the s_axis func field reads alloc
	`MQMM_ASSERT_NOW(a_no_overlap, clk, arst_n, $rose(m_axis_tvalid) && (cmd.func == FN_ALLOC), !$past(s_axis_tvalid && s_axis_tready))

endmodule

bind multi_queue_message_mailbox mqmm_checker u_mqmm_checker (.*);
